// File: sv/rar_pkg.sv
// Package for the rational arithmetic reduction block.
// Holds widths, operation codes, the divider status struct and a small helper.
// Used by rar_divider and rational_arith_reduce; depends on nothing else.
`default_nettype none

package rar_pkg;

    // Operand width and the widths that follow from it.
    localparam int OPERAND_WIDTH = 16;
    localparam int MAG_W         = 2 * OPERAND_WIDTH;
    localparam int OUT_W         = 33;
    localparam int CNT_W         = $clog2(MAG_W + 1);
    localparam int EXT_W         = (MAG_W + 1 > OUT_W) ? (MAG_W + 1) : OUT_W;
    localparam int MODE_W        = 3;

    // Operation codes.
    localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUB = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MUL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DIV = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CMP = 3'd4;

    // Status of the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Magnitude of a two's complement operand.
    function automatic logic [OPERAND_WIDTH-1:0] sm_mag(input logic [OPERAND_WIDTH-1:0] x);
        sm_mag = x[OPERAND_WIDTH-1] ? (~x + 1'b1) : x;
    endfunction

endpackage

`default_nettype wire

// File: sv/rar_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Shared by the gcd loop and the two final reductions; uses rar_pkg.
`default_nettype none

module rar_divider (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [rar_pkg::MAG_W-1:0] dividend,
    input  wire logic [rar_pkg::MAG_W-1:0] divisor,
    output logic      [rar_pkg::MAG_W-1:0] quotient,
    output logic      [rar_pkg::MAG_W-1:0] remainder,
    output rar_pkg::div_stat_t             stat
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [rar_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [rar_pkg::MAG_W-1:0]   rem_reg, rem_next;
    logic [rar_pkg::MAG_W-1:0]   quo_reg, quo_next;
    logic [rar_pkg::MAG_W-1:0]   dvs_reg, dvs_next;
    logic [rar_pkg::MAG_W:0]     shifted;
    logic [rar_pkg::MAG_W:0]     diff;
    logic                        ge;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        shifted   = {rem_reg, quo_reg[rar_pkg::MAG_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        ge        = (shifted >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? diff[rar_pkg::MAG_W-1:0] : shifted[rar_pkg::MAG_W-1:0];
            quo_next = {quo_reg[rar_pkg::MAG_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == rar_pkg::CNT_W'(rar_pkg::MAG_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = quo_reg;
    assign remainder   = rem_reg;
    assign stat.busy   = busy_reg;
    assign stat.done   = done_reg;

endmodule

`default_nettype wire

// File: sv/rational_arith_reduce.sv
// Rational add, subtract, multiply, divide and compare with gcd reduction.
// Steps: the multiply states ST_MUL0 and ST_MUL1 (and ST_MUL2 for add and subtract), a
// combine step, the gcd loop of divisions, then the numerator and denominator divisions.
// Compare goes to output after ST_MUL1, an error after the combine step, an unused mode
// after ST_MUL0. One item at a time; the next item is taken only back in the idle state.
// Synchronous active-low reset clears the sequencer and flags.
`default_nettype none

module rational_arith_reduce (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic        [rar_pkg::MODE_W-1:0]        s_mode,
    input  wire logic signed [rar_pkg::OPERAND_WIDTH-1:0] s_a_num,
    input  wire logic signed [rar_pkg::OPERAND_WIDTH-1:0] s_a_den,
    input  wire logic signed [rar_pkg::OPERAND_WIDTH-1:0] s_b_num,
    input  wire logic signed [rar_pkg::OPERAND_WIDTH-1:0] s_b_den,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic signed      [rar_pkg::OUT_W-1:0]         m_res_num,
    output logic signed      [rar_pkg::OUT_W-1:0]         m_res_den,
    output logic                                         m_is_equal,
    output logic                                         m_div_error
);

    localparam int OW = rar_pkg::OPERAND_WIDTH;
    localparam int MW = rar_pkg::MAG_W;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MUL0   = 4'd1;
    localparam logic [3:0] ST_MUL1   = 4'd2;
    localparam logic [3:0] ST_MUL2   = 4'd3;
    localparam logic [3:0] ST_COMB   = 4'd4;
    localparam logic [3:0] ST_GSTART = 4'd5;
    localparam logic [3:0] ST_GWAIT  = 4'd6;
    localparam logic [3:0] ST_NSTART = 4'd7;
    localparam logic [3:0] ST_NWAIT  = 4'd8;
    localparam logic [3:0] ST_DSTART = 4'd9;
    localparam logic [3:0] ST_DWAIT  = 4'd10;
    localparam logic [3:0] ST_OUT    = 4'd11;

    logic [3:0]                 state_reg, state_next;
    logic [rar_pkg::MODE_W-1:0] mode_reg;
    logic [OW-1:0]              an_reg, ad_reg, bn_reg, bd_reg;
    logic                       ans_reg, ads_reg, bns_reg, bds_reg;
    logic [MW-1:0]              x_reg, y_reg, z_reg;
    logic                       xs_reg, ys_reg, zs_reg;
    logic [MW-1:0]              num_reg, den_reg, m_reg, n_reg, qn_reg, qd_reg;
    logic                       nums_reg, dens_reg, ms_reg, ns_reg;
    logic                       err_reg, eq_reg;
    logic                       mv_reg;
    logic [rar_pkg::OUT_W-1:0]  rn_reg, rd_reg;
    logic                       req_reg, rerr_reg;

    logic [OW-1:0]              mul_a, mul_b;
    logic                       mul_s;
    logic [MW-1:0]              prod;
    logic                       prod_neg;
    logic                       ys_eff;
    logic [MW-1:0]              sum_mag;
    logic                       sum_neg;
    logic [MW-1:0]              cnum_mag, cden_mag;
    logic                       cnum_neg, cden_neg;
    logic                       div_start;
    logic [MW-1:0]              div_dvd;
    logic [MW-1:0]              div_q, div_r;
    rar_pkg::div_stat_t         div_stat;
    logic                       is_arith;
    logic                       out_free;

    // Two's complement view of a sign and magnitude, wrapped to the output width.
    function automatic logic [rar_pkg::OUT_W-1:0] to_out(input logic neg,
                                                        input logic [MW-1:0] mag);
        logic [rar_pkg::EXT_W-1:0] v;
        v = rar_pkg::EXT_W'(mag);
        if (neg) begin
            v = -v;
        end
        to_out = v[rar_pkg::OUT_W-1:0];
    endfunction

    assign is_arith = (mode_reg == rar_pkg::MODE_ADD) || (mode_reg == rar_pkg::MODE_SUB) ||
                      (mode_reg == rar_pkg::MODE_MUL) || (mode_reg == rar_pkg::MODE_DIV);
    assign out_free = !mv_reg || m_ready;

    // Shared multiplier: one product of two magnitudes per cycle.
    always_comb begin
        case (state_reg)
            ST_MUL0: begin
                mul_a = an_reg;
                mul_b = (mode_reg == rar_pkg::MODE_MUL) ? bn_reg : bd_reg;
                mul_s = ans_reg ^ ((mode_reg == rar_pkg::MODE_MUL) ? bns_reg : bds_reg);
            end
            ST_MUL1: begin
                mul_a = ad_reg;
                mul_b = (mode_reg == rar_pkg::MODE_MUL) ? bd_reg : bn_reg;
                mul_s = ads_reg ^ ((mode_reg == rar_pkg::MODE_MUL) ? bds_reg : bns_reg);
            end
            default: begin
                mul_a = ad_reg;
                mul_b = bd_reg;
                mul_s = ads_reg ^ bds_reg;
            end
        endcase
        prod     = MW'(mul_a) * MW'(mul_b);
        prod_neg = mul_s && (prod != '0);
    end

    // Sign and magnitude add of the two cross products, then pick num and den.
    always_comb begin
        ys_eff = ys_reg ^ (mode_reg == rar_pkg::MODE_SUB);
        if (xs_reg == ys_eff) begin
            sum_mag = x_reg + y_reg;
            sum_neg = xs_reg;
        end else if (x_reg >= y_reg) begin
            sum_mag = x_reg - y_reg;
            sum_neg = xs_reg;
        end else begin
            sum_mag = y_reg - x_reg;
            sum_neg = ys_eff;
        end
        if ((mode_reg == rar_pkg::MODE_ADD) || (mode_reg == rar_pkg::MODE_SUB)) begin
            cnum_mag = sum_mag;
            cnum_neg = sum_neg && (sum_mag != '0);
            cden_mag = z_reg;
            cden_neg = zs_reg;
        end else begin
            cnum_mag = x_reg;
            cnum_neg = xs_reg;
            cden_mag = y_reg;
            cden_neg = ys_reg;
        end
    end

    // Divider operand selection.
    always_comb begin
        div_start = (state_reg == ST_GSTART) || (state_reg == ST_NSTART) ||
                    (state_reg == ST_DSTART);
        case (state_reg)
            ST_GSTART: div_dvd = m_reg;
            ST_NSTART: div_dvd = num_reg;
            default:   div_dvd = den_reg;
        endcase
    end

    rar_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (n_reg),
        .quotient  (div_q),
        .remainder (div_r),
        .stat      (div_stat)
    );

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MUL0;
                end
            end
            ST_MUL0: begin
                state_next = is_arith || (mode_reg == rar_pkg::MODE_CMP) ? ST_MUL1 : ST_OUT;
            end
            ST_MUL1: begin
                if (mode_reg == rar_pkg::MODE_CMP) begin
                    state_next = ST_OUT;
                end else if ((mode_reg == rar_pkg::MODE_MUL) ||
                             (mode_reg == rar_pkg::MODE_DIV)) begin
                    state_next = ST_COMB;
                end else begin
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2:   state_next = ST_COMB;
            ST_COMB:   state_next = (cden_mag == '0) ? ST_OUT : ST_GSTART;
            ST_GSTART: state_next = ST_GWAIT;
            ST_GWAIT: begin
                if (div_stat.done) begin
                    state_next = (div_r == '0) ? ST_NSTART : ST_GSTART;
                end
            end
            ST_NSTART: state_next = ST_NWAIT;
            ST_NWAIT: begin
                if (div_stat.done) begin
                    state_next = ST_DSTART;
                end
            end
            ST_DSTART: state_next = ST_DWAIT;
            ST_DWAIT: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
            err_reg   <= 1'b0;
            eq_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == ST_OUT) && out_free) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
            if (state_reg == ST_IDLE) begin
                err_reg <= 1'b0;
                eq_reg  <= 1'b0;
            end else if (state_reg == ST_COMB) begin
                err_reg <= (cden_mag == '0);
            end else if ((state_reg == ST_MUL1) && (mode_reg == rar_pkg::MODE_CMP)) begin
                eq_reg <= (xs_reg == prod_neg) && (x_reg == prod);
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_IDLE) && s_valid) begin
            mode_reg <= s_mode;
            an_reg   <= rar_pkg::sm_mag(s_a_num);
            ad_reg   <= rar_pkg::sm_mag(s_a_den);
            bn_reg   <= rar_pkg::sm_mag(s_b_num);
            bd_reg   <= rar_pkg::sm_mag(s_b_den);
            ans_reg  <= s_a_num[OW-1];
            ads_reg  <= s_a_den[OW-1];
            bns_reg  <= s_b_num[OW-1];
            bds_reg  <= s_b_den[OW-1];
        end
        if (state_reg == ST_MUL0) begin
            x_reg  <= prod;
            xs_reg <= prod_neg;
        end
        if (state_reg == ST_MUL1) begin
            y_reg  <= prod;
            ys_reg <= prod_neg;
        end
        if (state_reg == ST_MUL2) begin
            z_reg  <= prod;
            zs_reg <= prod_neg;
        end
        if (state_reg == ST_COMB) begin
            num_reg  <= cnum_mag;
            nums_reg <= cnum_neg;
            den_reg  <= cden_mag;
            dens_reg <= cden_neg;
            m_reg    <= cnum_mag;
            ms_reg   <= cnum_neg;
            n_reg    <= cden_mag;
            ns_reg   <= cden_neg;
        end
        // Euclid step: the remainder takes the sign of the dividend.
        if ((state_reg == ST_GWAIT) && div_stat.done && (div_r != '0)) begin
            m_reg  <= n_reg;
            ms_reg <= ns_reg;
            n_reg  <= div_r;
            ns_reg <= ms_reg;
        end
        if ((state_reg == ST_NWAIT) && div_stat.done) begin
            qn_reg <= div_q;
        end
        if ((state_reg == ST_DWAIT) && div_stat.done) begin
            qd_reg <= div_q;
        end
        // Output stage.
        if ((state_reg == ST_OUT) && out_free) begin
            if (is_arith && !err_reg) begin
                rn_reg <= to_out(nums_reg ^ ns_reg && (qn_reg != '0), qn_reg);
                rd_reg <= to_out(dens_reg ^ ns_reg && (qd_reg != '0), qd_reg);
            end else begin
                rn_reg <= '0;
                rd_reg <= '0;
            end
            req_reg  <= eq_reg && (mode_reg == rar_pkg::MODE_CMP);
            rerr_reg <= err_reg && is_arith;
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = mv_reg;
    assign m_res_num   = rn_reg;
    assign m_res_den   = rd_reg;
    assign m_is_equal  = req_reg;
    assign m_div_error = rerr_reg;

    // The divider is only started when it is free.
    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // An error result carries zero parts and no equality.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && rerr_reg) |-> (rn_reg == '0) && (rd_reg == '0) && !req_reg)
        else $error("error result with nonzero parts");

    // Input is never taken while the gcd loop runs.
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_GWAIT) |-> !s_ready)
        else $error("ready during gcd");

endmodule

`default_nettype wire

// File: tb/rational_arith_reduce_test.sv
// Self-checking testbench for rational_arith_reduce: fraction arithmetic with gcd reduction.
// Predicts each result as signed values and compares it with the monitored beats.
// Depends on rar_pkg and the rational_arith_reduce RTL.
`timescale 1ns / 1ps

module rational_arith_reduce_test;

    localparam int W = rar_pkg::OPERAND_WIDTH;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [rar_pkg::MODE_W-1:0] mode;
        logic [W-1:0]      a_num;
        logic [W-1:0]      a_den;
        logic [W-1:0]      b_num;
        logic [W-1:0]      b_den;
    } frac_op_t;

    typedef struct packed {
        logic [rar_pkg::OUT_W-1:0] num;
        logic [rar_pkg::OUT_W-1:0] den;
        logic             eq;
        logic             err;
    } frac_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [rar_pkg::MODE_W-1:0] s_mode = '0;
    logic signed [W-1:0] s_a_num = '0, s_a_den = '0, s_b_num = '0, s_b_den = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [rar_pkg::OUT_W-1:0] m_res_num, m_res_den;
    logic m_is_equal, m_div_error;

    frac_op_t  pending_ops[$];
    frac_res_t expected_results[$];
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    bit        stimulus_done = 1'b0;
    bit        hold_sender = 1'b0;
    int        burst_left = 0;
    int        gap_left = 0;
    int        long_stall = 0;
    bit        want_long_stall = 1'b0;

    rational_arith_reduce i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_a_num(s_a_num), .s_a_den(s_a_den), .s_b_num(s_b_num), .s_b_den(s_b_den),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_res_num(m_res_num), .m_res_den(m_res_den),
        .m_is_equal(m_is_equal), .m_div_error(m_div_error)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Signed value of a field, held exactly in 64 bits.
    function automatic longint field_value(input logic [W-1:0] x);
        return longint'($signed(x));
    endfunction

    // Reduce num/den by a truncating-remainder gcd whose sign follows the dividend.
    function automatic frac_res_t reduce_fraction(input frac_op_t op);
        frac_res_t res;
        longint an, ad, bn, bd, n, d, m, g, r;
        an = field_value(op.a_num);
        ad = field_value(op.a_den);
        bn = field_value(op.b_num);
        bd = field_value(op.b_den);
        res = '0;
        case (op.mode)
            rar_pkg::MODE_ADD: begin n = an * bd + ad * bn; d = ad * bd; end
            rar_pkg::MODE_SUB: begin n = an * bd - ad * bn; d = ad * bd; end
            rar_pkg::MODE_MUL: begin n = an * bn; d = ad * bd; end
            rar_pkg::MODE_DIV: begin n = an * bd; d = ad * bn; end
            rar_pkg::MODE_CMP: begin
                res.eq = (an * bd == bn * ad);
                return res;
            end
            default: return res;
        endcase
        if (d == 0) begin
            res.err = 1'b1;
            return res;
        end
        // The 64-bit % truncates toward zero, taking the sign of the dividend.
        m = n;
        g = d;
        r = m % g;
        while (r != 0) begin
            m = g;
            g = r;
            r = m % g;
        end
        res.num = rar_pkg::OUT_W'(n / g);
        res.den = rar_pkg::OUT_W'(d / g);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        mismatch_count++;
    endtask

    task automatic queue_op(input logic [rar_pkg::MODE_W-1:0] mode, input longint an,
                            input longint ad, input longint bn, input longint bd);
        frac_op_t op;
        op.mode = mode;
        op.a_num = W'(an);
        op.a_den = W'(ad);
        op.b_num = W'(bn);
        op.b_den = W'(bd);
        pending_ops.push_back(op);
    endtask

    function automatic logic [W-1:0] random_operand();
        case ($urandom_range(0, 5))
            0: return W'($signed($urandom_range(0, 16)) - 8);
            1: return $urandom_range(0, 1) ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
            2: return W'($urandom_range(0, 255)) - W'(128);
            default: return W'($urandom);
        endcase
    endfunction

    // Sender: bursts of random length with random gaps between them.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(reduce_fraction(pending_ops.pop_front()));
            end
            if (!(s_valid && !s_ready)) begin
                if (pending_ops.size() > 0 && !hold_sender && gap_left == 0) begin
                    s_valid <= 1'b1;
                    {s_mode, s_a_num, s_a_den, s_b_num, s_b_den} <= pending_ops[0];
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 60);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                    if (gap_left > 0) begin
                        gap_left <= gap_left - 1;
                    end
                end
            end
        end
    end

    // Note: pending_ops[0] is the beat being offered; it is popped on acceptance above.

    // Receiver: its own stall pattern plus one long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (want_long_stall && long_stall == 0) begin
            long_stall <= 3000;
            want_long_stall <= 1'b0;
            m_ready <= 1'b0;
        end else if (long_stall > 0) begin
            long_stall <= long_stall - 1;
            m_ready <= (long_stall == 1);
        end else begin
            case (($urandom_range(0, 3)))
                0: m_ready <= 1'b0;
                default: m_ready <= 1'b1;
            endcase
        end
    end

    // Monitor: compare each accepted result beat with the oldest expectation.
    always @(posedge aclk) begin
        frac_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected beat", m_res_num, 0);
            end else begin
                want = expected_results.pop_front();
                if (m_res_num !== want.num) begin
                    report_mismatch("res_num", m_res_num, $signed(want.num));
                end
                if (m_res_den !== want.den) begin
                    report_mismatch("res_den", m_res_den, $signed(want.den));
                end
                if (m_is_equal !== want.eq) begin
                    report_mismatch("is_equal", m_is_equal, want.eq);
                end
                if (m_div_error !== want.err) begin
                    report_mismatch("div_error", m_div_error, want.err);
                end
            end
        end
    end

    // Watchdog: ends the run after a long stretch with no beat on either side.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        longint mn, mx;
        int k;
        mn = -32768;
        mx = 32767;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, every operation, zero numerator, zero denominator, unused modes.
        queue_op(rar_pkg::MODE_ADD, 1, 2, 1, 3);
        queue_op(rar_pkg::MODE_SUB, 1, 2, 1, 2);
        queue_op(rar_pkg::MODE_MUL, mn, mn, mn, mn);
        queue_op(rar_pkg::MODE_MUL, mx, mn, mn, mx);
        queue_op(rar_pkg::MODE_DIV, mn, mx, mn, -1);
        queue_op(rar_pkg::MODE_ADD, mn, mn, mn, mn);
        queue_op(rar_pkg::MODE_SUB, mx, mn, mn, mx);
        queue_op(rar_pkg::MODE_ADD, 3, -4, 5, 6);
        queue_op(rar_pkg::MODE_DIV, 7, 3, 0, 5);
        queue_op(rar_pkg::MODE_ADD, 1, 0, 1, 1);
        queue_op(rar_pkg::MODE_MUL, 5, 3, 2, 0);
        queue_op(rar_pkg::MODE_MUL, 0, -7, 3, 2);
        queue_op(rar_pkg::MODE_CMP, 1, 2, 2, 4);
        queue_op(rar_pkg::MODE_CMP, 1, 2, -2, 4);
        queue_op(rar_pkg::MODE_CMP, mn, mn, mx, mx);
        queue_op(rar_pkg::MODE_CMP, 0, 0, 5, 0);
        queue_op(3'd5, 1, 2, 3, 4);
        queue_op(3'd6, mn, mx, mn, mx);
        queue_op(3'd7, -1, -1, -1, -1);
        queue_op(rar_pkg::MODE_SUB, -6, -9, 4, -6);
        queue_op(rar_pkg::MODE_DIV, -12, 18, -8, 6);

        // Random items: mostly valid modes, a few unused codes.
        for (k = 0; k < 1830; k++) begin
            frac_op_t op;
            op.mode = $urandom_range(0, 19) == 0
                      ? rar_pkg::MODE_W'($urandom_range(5, 7))
                      : rar_pkg::MODE_W'($urandom_range(0, 4));
            op.a_num = random_operand();
            op.a_den = random_operand();
            op.b_num = random_operand();
            op.b_den = random_operand();
            pending_ops.push_back(op);
            if (k == 400) begin
                // Long receiver hold-off while the sender keeps offering.
                want_long_stall <= 1'b1;
            end
            if (k == 900) begin
                // Sender pause until every result is back.
                wait (pending_ops.size() == 0 && !s_valid);
                hold_sender = 1'b1;
                wait (expected_results.size() == 0);
                hold_sender = 1'b0;
            end
        end

        wait (pending_ops.size() == 0 && !s_valid);
        wait (expected_results.size() == 0);
        repeat (400) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// File: files.f
sv/rar_pkg.sv
sv/rar_divider.sv
sv/rational_arith_reduce.sv
tb/rational_arith_reduce_test.sv
